// ----- hdl/nmsp_pkg.sv -----
// Shared types and constants for the nearest-centre shortest-path block.
// Used by the controller, the datapath and the top level; depends on nothing.
package nmsp_pkg;

   localparam int DIST_W   = 17;
   localparam int WEIGHT_W = 16;
   localparam int FIELD_CITY_W = 6;

   localparam logic [DIST_W-1:0] DIST_INF = 17'd99999;

   localparam logic [1:0] CMD_ADD_CITY = 2'd0;
   localparam logic [1:0] CMD_ADD_ROAD = 2'd1;
   localparam logic [1:0] CMD_QUERY    = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_REJECT    = 2'd1;
   localparam logic [1:0] ST_NO_CENTER = 2'd2;

   localparam logic [1:0] RD_IDX  = 2'd0;
   localparam logic [1:0] RD_NB   = 2'd1;
   localparam logic [1:0] RD_WALK = 2'd2;

   typedef struct packed {
      logic       capture;
      logic       add_city;
      logic       add_road;
      logic       init_wr;
      logic       idx_clear;
      logic       idx_inc;
      logic       scan_clear;
      logic       scan_eval;
      logic       settle_wr;
      logic       road_idx_clear;
      logic       road_idx_inc;
      logic       road_latch;
      logic [1:0] node_rd_sel;
      logic       relax_b;
      logic       relax_wr;
      logic       pick_clear;
      logic       pick_eval;
      logic       walk_start;
      logic       walk_wr;
      logic       walk_step;
      logic       emit_dec;
      logic       rsp_single;
      logic       rsp_route;
      logic [1:0] status;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       city_ok;
      logic       road_ok;
      logic       src_ok;
      logic       idx_last;
      logic       cur_valid;
      logic       road_none;
      logic       road_last;
      logic       match_a;
      logic       match_b;
      logic       best_valid;
      logic       pred_has;
      logic       route_one;
      logic       out_free;
   } ctrl_stat_type;

endpackage

// ----- hdl/nmsp_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module nmsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/nmsp_dpath.sv -----
// Datapath: city, road, node and route memories, counters and the result register.
// Depends on nmsp_pkg and nmsp_ram; driven by nmsp_ctrl.
module nmsp_dpath #(
   parameter int MAX_CITIES = 64,
   parameter int MAX_ROADS  = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             req_cmd,
   input  logic                   req_has_center,
   input  logic [5:0]             req_city_a,
   input  logic [5:0]             req_city_b,
   input  logic [15:0]            req_road_weight,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status,
   output logic [5:0]             rsp_center_city,
   output logic [16:0]            rsp_total_distance,
   output logic [5:0]             rsp_path_city,
   output logic                   rsp_last,
   input  nmsp_pkg::ctrl_cmd_type cmd,
   output nmsp_pkg::ctrl_stat_type stat
);
   import nmsp_pkg::*;

   localparam int CIW   = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
   localparam int CCW   = $clog2(MAX_CITIES + 1);
   localparam int RIW   = (MAX_ROADS > 1) ? $clog2(MAX_ROADS) : 1;
   localparam int RCW   = $clog2(MAX_ROADS + 1);
   localparam int RDW   = 2 * CIW + WEIGHT_W;
   localparam int NDW   = DIST_W + CIW + 2;
   localparam int N_HAS = DIST_W + CIW;
   localparam int N_SET = DIST_W + CIW + 1;

   logic [CCW-1:0]      city_count_ff, city_count_in;
   logic [RCW-1:0]      road_count_ff, road_count_in;
   logic [1:0]          cmd_ff, cmd_in;
   logic                mark_ff, mark_in;
   logic [5:0]          a_ff, a_in, b_ff, b_in;
   logic [WEIGHT_W-1:0] w_ff, w_in;
   logic [CCW-1:0]      idx_ff, idx_in;
   logic [RCW-1:0]      road_idx_ff, road_idx_in;
   logic [DIST_W-1:0]   least_ff, least_in;
   logic [CIW-1:0]      cur_ff, cur_in;
   logic                cur_valid_ff, cur_valid_in;
   logic                cur_has_ff, cur_has_in;
   logic [CIW-1:0]      cur_pred_ff, cur_pred_in;
   logic [CIW-1:0]      ra_ff, ra_in, rb_ff, rb_in;
   logic [WEIGHT_W-1:0] rl_ff, rl_in;
   logic [CIW-1:0]      best_ff, best_in;
   logic [DIST_W-1:0]   bestd_ff, bestd_in;
   logic                best_valid_ff, best_valid_in;
   logic [CIW-1:0]      v_ff, v_in;
   logic [CCW-1:0]      n_ff, n_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [5:0]          rsp_center_ff, rsp_center_in;
   logic [DIST_W-1:0]   rsp_dist_ff, rsp_dist_in;
   logic [5:0]          rsp_path_ff, rsp_path_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                flag_q;
   logic [RDW-1:0]      road_q;
   logic [NDW-1:0]      node_q;
   logic [CIW-1:0]      route_q;
   logic                node_we;
   logic [CIW-1:0]      node_wa, node_ra, nb;
   logic [NDW-1:0]      node_wd;
   logic [DIST_W-1:0]   nq_dist;
   logic [CIW-1:0]      nq_pred;
   logic                nq_has, nq_set;
   logic [DIST_W:0]     sum;
   logic                better, a_lt, b_lt, out_free;

   assign nq_dist = node_q[DIST_W-1:0];
   assign nq_pred = node_q[N_HAS-1:DIST_W];
   assign nq_has  = node_q[N_HAS];
   assign nq_set  = node_q[N_SET];
   assign nb      = cmd.relax_b ? ra_ff : rb_ff;
   assign sum     = {1'b0, least_ff} + {2'b00, rl_ff};
   assign better  = sum < {1'b0, nq_dist};
   assign a_lt    = {1'b0, a_ff} < 7'(city_count_ff);
   assign b_lt    = {1'b0, b_ff} < 7'(city_count_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      node_we = 1'b0;
      node_wa = idx_ff[CIW-1:0];
      node_wd = {2'b00, {CIW{1'b0}}, DIST_INF};
      if (cmd.init_wr) begin
         node_we = 1'b1;
         if (idx_ff[CIW-1:0] == a_ff[CIW-1:0]) begin
            node_wd = '0;
         end
      end else if (cmd.settle_wr) begin
         node_we = 1'b1;
         node_wa = cur_ff;
         node_wd = {1'b1, cur_has_ff, cur_pred_ff, least_ff};
      end else if (cmd.relax_wr && better) begin
         node_we = 1'b1;
         node_wa = nb;
         node_wd = {nq_set, 1'b1, cur_ff, sum[DIST_W-1:0]};
      end
   end

   always_comb begin
      case (cmd.node_rd_sel)
         RD_NB:   node_ra = nb;
         RD_WALK: node_ra = v_ff;
         default: node_ra = idx_ff[CIW-1:0];
      endcase
   end

   nmsp_ram #(.WIDTH(1), .DEPTH(MAX_CITIES)) u_flag_ram (
      .clock   (clock),
      .wr_en   (cmd.add_city),
      .wr_addr (city_count_ff[CIW-1:0]),
      .wr_data (mark_ff),
      .rd_addr (idx_ff[CIW-1:0]),
      .rd_data (flag_q)
   );

   nmsp_ram #(.WIDTH(RDW), .DEPTH(MAX_ROADS)) u_road_ram (
      .clock   (clock),
      .wr_en   (cmd.add_road),
      .wr_addr (road_count_ff[RIW-1:0]),
      .wr_data ({a_ff[CIW-1:0], b_ff[CIW-1:0], w_ff}),
      .rd_addr (road_idx_ff[RIW-1:0]),
      .rd_data (road_q)
   );

   nmsp_ram #(.WIDTH(NDW), .DEPTH(MAX_CITIES)) u_node_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (node_wa),
      .wr_data (node_wd),
      .rd_addr (node_ra),
      .rd_data (node_q)
   );

   nmsp_ram #(.WIDTH(CIW), .DEPTH(MAX_CITIES)) u_route_ram (
      .clock   (clock),
      .wr_en   (cmd.walk_wr),
      .wr_addr (n_ff[CIW-1:0]),
      .wr_data (v_ff),
      .rd_addr (CIW'(n_ff - 1'b1)),
      .rd_data (route_q)
   );

   always_comb begin
      city_count_in = city_count_ff;
      road_count_in = road_count_ff;
      cmd_in        = cmd_ff;
      mark_in       = mark_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      w_in          = w_ff;
      idx_in        = idx_ff;
      road_idx_in   = road_idx_ff;
      least_in      = least_ff;
      cur_in        = cur_ff;
      cur_valid_in  = cur_valid_ff;
      cur_has_in    = cur_has_ff;
      cur_pred_in   = cur_pred_ff;
      ra_in         = ra_ff;
      rb_in         = rb_ff;
      rl_in         = rl_ff;
      best_in       = best_ff;
      bestd_in      = bestd_ff;
      best_valid_in = best_valid_ff;
      v_in          = v_ff;
      n_in          = n_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_center_in = rsp_center_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_path_in   = rsp_path_ff;
      rsp_last_in   = rsp_last_ff;

      if (cmd.capture) begin
         cmd_in  = req_cmd;
         mark_in = req_has_center;
         a_in    = req_city_a;
         b_in    = req_city_b;
         w_in    = req_road_weight;
      end
      if (cmd.add_city) begin
         city_count_in = CCW'(city_count_ff + 1'b1);
      end
      if (cmd.add_road) begin
         road_count_in = RCW'(road_count_ff + 1'b1);
      end
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = CCW'(idx_ff + 1'b1);
      end
      if (cmd.road_idx_clear) begin
         road_idx_in = '0;
      end else if (cmd.road_idx_inc) begin
         road_idx_in = RCW'(road_idx_ff + 1'b1);
      end
      if (cmd.scan_clear) begin
         least_in     = DIST_INF;
         cur_valid_in = 1'b0;
      end else if (cmd.scan_eval && !nq_set && (nq_dist < least_ff)) begin
         least_in     = nq_dist;
         cur_in       = idx_ff[CIW-1:0];
         cur_valid_in = 1'b1;
         cur_has_in   = nq_has;
         cur_pred_in  = nq_pred;
      end
      if (cmd.road_latch) begin
         ra_in = road_q[RDW-1:CIW+WEIGHT_W];
         rb_in = road_q[CIW+WEIGHT_W-1:WEIGHT_W];
         rl_in = road_q[WEIGHT_W-1:0];
      end
      if (cmd.pick_clear) begin
         bestd_in      = DIST_INF;
         best_valid_in = 1'b0;
      end else if (cmd.pick_eval && flag_q && (nq_dist < bestd_ff)) begin
         bestd_in      = nq_dist;
         best_in       = idx_ff[CIW-1:0];
         best_valid_in = 1'b1;
      end
      if (cmd.walk_start) begin
         v_in = best_ff;
         n_in = '0;
      end else if (cmd.walk_wr) begin
         n_in = CCW'(n_ff + 1'b1);
      end else if (cmd.walk_step && nq_has) begin
         v_in = nq_pred;
      end else if (cmd.emit_dec) begin
         n_in = CCW'(n_ff - 1'b1);
      end
      if (cmd.rsp_single) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = cmd.status;
         rsp_center_in = '0;
         rsp_dist_in   = '0;
         rsp_path_in   = '0;
         rsp_last_in   = 1'b1;
      end else if (cmd.rsp_route) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_OK;
         rsp_center_in = FIELD_CITY_W'(best_ff);
         rsp_dist_in   = bestd_ff;
         rsp_path_in   = FIELD_CITY_W'(route_q);
         rsp_last_in   = (n_ff == CCW'(1));
      end else if (rsp_ready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         city_count_ff <= '0;
         road_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         city_count_ff <= city_count_in;
         road_count_ff <= road_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      mark_ff       <= mark_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      w_ff          <= w_in;
      idx_ff        <= idx_in;
      road_idx_ff   <= road_idx_in;
      least_ff      <= least_in;
      cur_ff        <= cur_in;
      cur_valid_ff  <= cur_valid_in;
      cur_has_ff    <= cur_has_in;
      cur_pred_ff   <= cur_pred_in;
      ra_ff         <= ra_in;
      rb_ff         <= rb_in;
      rl_ff         <= rl_in;
      best_ff       <= best_in;
      bestd_ff      <= bestd_in;
      best_valid_ff <= best_valid_in;
      v_ff          <= v_in;
      n_ff          <= n_in;
      rsp_status_ff <= rsp_status_in;
      rsp_center_ff <= rsp_center_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_path_ff   <= rsp_path_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign stat.cmd        = cmd_ff;
   assign stat.city_ok    = (city_count_ff != CCW'(MAX_CITIES));
   assign stat.road_ok    = a_lt && b_lt && (road_count_ff != RCW'(MAX_ROADS));
   assign stat.src_ok     = a_lt;
   assign stat.idx_last   = (CCW'(idx_ff + 1'b1) == city_count_ff);
   assign stat.cur_valid  = cur_valid_ff;
   assign stat.road_none  = (road_count_ff == '0);
   assign stat.road_last  = (RCW'(road_idx_ff + 1'b1) == road_count_ff);
   assign stat.match_a    = (ra_ff == cur_ff);
   assign stat.match_b    = (rb_ff == cur_ff);
   assign stat.best_valid = best_valid_ff;
   assign stat.pred_has   = nq_has;
   assign stat.route_one  = (n_ff == CCW'(1));
   assign stat.out_free   = out_free;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_center_city    = rsp_center_ff;
   assign rsp_total_distance = rsp_dist_ff;
   assign rsp_path_city      = rsp_path_ff;
   assign rsp_last           = rsp_last_ff;

`ifndef SYNTH
   a_city_bound: assert property (@(posedge clock) disable iff (reset)
      city_count_ff <= CCW'(MAX_CITIES))
      else $error("City count beyond capacity.");
   a_road_bound: assert property (@(posedge clock) disable iff (reset)
      road_count_ff <= RCW'(MAX_ROADS))
      else $error("Road count beyond capacity.");
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_single || cmd.rsp_route) |-> out_free)
      else $error("Result register overwritten before its transaction.");
   a_node_wr: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.init_wr, cmd.settle_wr, cmd.relax_wr}))
      else $error("Conflicting node memory writes.");
`endif

endmodule

// ----- hdl/nmsp_ctrl.sv -----
// Controller state machine: sequences decode, search rounds, centre pick and route output.
// Depends on nmsp_pkg; drives nmsp_dpath through the command struct.
module nmsp_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  nmsp_pkg::ctrl_stat_type stat,
   output nmsp_pkg::ctrl_cmd_type  cmd
);
   import nmsp_pkg::*;

   localparam logic [4:0] S_IDLE       = 5'd0;
   localparam logic [4:0] S_DECODE     = 5'd1;
   localparam logic [4:0] S_RESP       = 5'd2;
   localparam logic [4:0] S_INIT       = 5'd3;
   localparam logic [4:0] S_SCAN_START = 5'd4;
   localparam logic [4:0] S_SCAN_RD    = 5'd5;
   localparam logic [4:0] S_SCAN_EV    = 5'd6;
   localparam logic [4:0] S_SCAN_DONE  = 5'd7;
   localparam logic [4:0] S_ROAD_RD    = 5'd8;
   localparam logic [4:0] S_ROAD_EV    = 5'd9;
   localparam logic [4:0] S_CHK_A      = 5'd10;
   localparam logic [4:0] S_RELAX_A    = 5'd11;
   localparam logic [4:0] S_CHK_B      = 5'd12;
   localparam logic [4:0] S_RELAX_B    = 5'd13;
   localparam logic [4:0] S_NEXT_ROAD  = 5'd14;
   localparam logic [4:0] S_PICK_START = 5'd15;
   localparam logic [4:0] S_PICK_RD    = 5'd16;
   localparam logic [4:0] S_PICK_EV    = 5'd17;
   localparam logic [4:0] S_PICK_DONE  = 5'd18;
   localparam logic [4:0] S_WALK_RD    = 5'd19;
   localparam logic [4:0] S_WALK_EV    = 5'd20;
   localparam logic [4:0] S_EMIT_RD    = 5'd21;
   localparam logic [4:0] S_EMIT_OUT   = 5'd22;

   logic [4:0] state_ff, state_in;
   logic [1:0] code_ff, code_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      cmd      = '0;
      cmd.node_rd_sel = RD_IDX;
      cmd.status      = code_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            code_in  = ST_REJECT;
            state_in = S_RESP;
            case (stat.cmd)
               CMD_ADD_CITY: begin
                  if (stat.city_ok) begin
                     cmd.add_city = 1'b1;
                     code_in      = ST_OK;
                  end
               end
               CMD_ADD_ROAD: begin
                  if (stat.road_ok) begin
                     cmd.add_road = 1'b1;
                     code_in      = ST_OK;
                  end
               end
               CMD_QUERY: begin
                  if (stat.src_ok) begin
                     cmd.idx_clear = 1'b1;
                     state_in      = S_INIT;
                  end
               end
               default: begin
                  code_in = ST_REJECT;
               end
            endcase
         end
         S_RESP: begin
            if (stat.out_free) begin
               cmd.rsp_single = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_INIT: begin
            cmd.init_wr = 1'b1;
            cmd.idx_inc = 1'b1;
            if (stat.idx_last) begin
               state_in = S_SCAN_START;
            end
         end
         S_SCAN_START: begin
            cmd.idx_clear  = 1'b1;
            cmd.scan_clear = 1'b1;
            state_in       = S_SCAN_RD;
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_EV;
         end
         S_SCAN_EV: begin
            cmd.scan_eval = 1'b1;
            cmd.idx_inc   = 1'b1;
            state_in      = stat.idx_last ? S_SCAN_DONE : S_SCAN_RD;
         end
         S_SCAN_DONE: begin
            if (stat.cur_valid) begin
               cmd.settle_wr      = 1'b1;
               cmd.road_idx_clear = 1'b1;
               state_in = stat.road_none ? S_SCAN_START : S_ROAD_RD;
            end else begin
               state_in = S_PICK_START;
            end
         end
         S_ROAD_RD: begin
            state_in = S_ROAD_EV;
         end
         S_ROAD_EV: begin
            cmd.road_latch = 1'b1;
            state_in       = S_CHK_A;
         end
         S_CHK_A: begin
            if (stat.match_a) begin
               cmd.node_rd_sel = RD_NB;
               state_in        = S_RELAX_A;
            end else begin
               state_in = S_CHK_B;
            end
         end
         S_RELAX_A: begin
            cmd.relax_wr = 1'b1;
            state_in     = S_CHK_B;
         end
         S_CHK_B: begin
            if (stat.match_b) begin
               cmd.node_rd_sel = RD_NB;
               cmd.relax_b     = 1'b1;
               state_in        = S_RELAX_B;
            end else begin
               state_in = S_NEXT_ROAD;
            end
         end
         S_RELAX_B: begin
            cmd.relax_b  = 1'b1;
            cmd.relax_wr = 1'b1;
            state_in     = S_NEXT_ROAD;
         end
         S_NEXT_ROAD: begin
            if (stat.road_last) begin
               state_in = S_SCAN_START;
            end else begin
               cmd.road_idx_inc = 1'b1;
               state_in         = S_ROAD_RD;
            end
         end
         S_PICK_START: begin
            cmd.idx_clear  = 1'b1;
            cmd.pick_clear = 1'b1;
            state_in       = S_PICK_RD;
         end
         S_PICK_RD: begin
            state_in = S_PICK_EV;
         end
         S_PICK_EV: begin
            cmd.pick_eval = 1'b1;
            cmd.idx_inc   = 1'b1;
            state_in      = stat.idx_last ? S_PICK_DONE : S_PICK_RD;
         end
         S_PICK_DONE: begin
            if (stat.best_valid) begin
               cmd.walk_start = 1'b1;
               state_in       = S_WALK_RD;
            end else begin
               code_in  = ST_NO_CENTER;
               state_in = S_RESP;
            end
         end
         S_WALK_RD: begin
            cmd.node_rd_sel = RD_WALK;
            cmd.walk_wr     = 1'b1;
            state_in        = S_WALK_EV;
         end
         S_WALK_EV: begin
            cmd.walk_step = 1'b1;
            state_in      = stat.pred_has ? S_WALK_RD : S_EMIT_RD;
         end
         S_EMIT_RD: begin
            state_in = S_EMIT_OUT;
         end
         S_EMIT_OUT: begin
            if (stat.out_free) begin
               cmd.rsp_route = 1'b1;
               cmd.emit_dec  = 1'b1;
               state_in      = stat.route_one ? S_IDLE : S_EMIT_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= ST_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule

// ----- hdl/nearest_marked_node_shortest_path_top.sv -----
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    cmd, has_center, city_a, city_b, road_weight
// rsp      out        rsp_valid/rsp_ready    status, center_city, total_distance, path_city, last
// Add city, add road and rejected items pass through the decode and response states to their single result.
// A query runs search rounds, picks the nearest marked city and emits its route; every search round
// scans all cities and all roads.
// Reset clears the city and road counts and the control state; no clearing pass is needed.
// A stalled result holds the block in its output state; a new transaction is taken when idle.
// Top level of the nearest service-centre search; depends on nmsp_pkg, nmsp_ctrl, nmsp_dpath.
module nearest_marked_node_shortest_path_top #(
   parameter int MAX_CITIES = 64,
   parameter int MAX_ROADS  = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_cmd,
   input  logic        req_has_center,
   input  logic [5:0]  req_city_a,
   input  logic [5:0]  req_city_b,
   input  logic [15:0] req_road_weight,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [5:0]  rsp_center_city,
   output logic [16:0] rsp_total_distance,
   output logic [5:0]  rsp_path_city,
   output logic        rsp_last
);
   import nmsp_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   nmsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   nmsp_dpath #(.MAX_CITIES(MAX_CITIES), .MAX_ROADS(MAX_ROADS)) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .req_cmd            (req_cmd),
      .req_has_center     (req_has_center),
      .req_city_a         (req_city_a),
      .req_city_b         (req_city_b),
      .req_road_weight    (req_road_weight),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_center_city    (rsp_center_city),
      .rsp_total_distance (rsp_total_distance),
      .rsp_path_city      (rsp_path_city),
      .rsp_last           (rsp_last),
      .cmd                (cmd),
      .stat               (stat)
   );

endmodule

// ----- test/nearest_marked_node_shortest_path_top_test.sv -----
// Self-checking testbench for the nearest service-centre shortest-path block.
// Drives cities, roads and queries with random idling and checks every route result
// against a behavioural predictor; depends on nmsp_pkg and the top-level RTL.
`timescale 1ns / 1ps

module nearest_marked_node_shortest_path_top_test;
   import nmsp_pkg::*;

   localparam int NCITY = 64;
   localparam int NROAD = 256;
   localparam int WATCHDOG = 2000000;

   typedef struct packed {
      logic [1:0]  status;
      logic [5:0]  center;
      logic [16:0] total;
      logic [5:0]  city;
      logic        last;
   } route_rsp_type;

   typedef struct {
      logic [1:0]  cmd;
      logic        mark;
      logic [5:0]  a;
      logic [5:0]  b;
      logic [15:0] w;
      bit          typed;
      logic [1:0]  want_status;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_cmd = '0;
   logic req_has_center = 1'b0;
   logic [5:0] req_city_a = '0;
   logic [5:0] req_city_b = '0;
   logic [15:0] req_road_weight = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [5:0] rsp_center_city;
   logic [16:0] rsp_total_distance;
   logic [5:0] rsp_path_city;
   logic rsp_last;

   nearest_marked_node_shortest_path_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state.
   int unsigned n_cities, n_roads;
   bit marked [NCITY];
   int unsigned end_a [NROAD], end_b [NROAD], road_len [NROAD];
   route_rsp_type route_q[$];

   int errors = 0;
   int n_rsp = 0, n_routes = 0, n_query = 0, n_items = 0;
   int idle_cycles = 0;
   int send_idle = 0, recv_stall = 0;
   bit tx_accept;

   function automatic route_rsp_type single(logic [1:0] st);
      route_rsp_type r;
      r = '{status: st, center: '0, total: '0, city: '0, last: 1'b1};
      return r;
   endfunction

   function automatic void add_expected(route_rsp_type r);
      route_q = {route_q, r};
   endfunction

   task automatic predict_centre(input logic [1:0] cmd, input logic mark,
                                 input int unsigned a, input int unsigned b,
                                 input int unsigned w);
      int unsigned best_dist [NCITY];
      int unsigned pred [NCITY];
      bit done [NCITY];
      int unsigned cur, least, best, bestd, v, n, nb, s;
      int unsigned route [NCITY];
      route_rsp_type r;
      if (cmd == CMD_ADD_CITY) begin
         if (n_cities >= NCITY) add_expected(single(ST_REJECT));
         else begin
            marked[n_cities] = mark;
            n_cities++;
            add_expected(single(ST_OK));
         end
      end else if (cmd == CMD_ADD_ROAD) begin
         if (a >= n_cities || b >= n_cities || n_roads >= NROAD)
            add_expected(single(ST_REJECT));
         else begin
            end_a[n_roads] = a;
            end_b[n_roads] = b;
            road_len[n_roads] = w;
            n_roads++;
            add_expected(single(ST_OK));
         end
      end else if (cmd == CMD_QUERY) begin
         if (a >= n_cities) begin
            add_expected(single(ST_REJECT));
            return;
         end
         for (int i = 0; i < NCITY; i++) begin
            best_dist[i] = DIST_INF;
            pred[i] = 127;
            done[i] = 0;
         end
         best_dist[a] = 0;
         forever begin
            cur = 127;
            least = DIST_INF;
            for (int i = 0; i < n_cities; i++)
               if (!done[i] && best_dist[i] < least) begin
                  least = best_dist[i];
                  cur = i;
               end
            if (cur == 127) break;
            done[cur] = 1;
            for (int k = 0; k < n_roads; k++)
               for (int e = 0; e < 2; e++) begin
                  if ((e == 0 ? end_a[k] : end_b[k]) == cur) begin
                     nb = (e == 0) ? end_b[k] : end_a[k];
                     s = best_dist[cur] + road_len[k];
                     if (nb < n_cities && s < best_dist[nb]) begin
                        best_dist[nb] = s;
                        pred[nb] = cur;
                     end
                  end
               end
         end
         best = 127;
         bestd = DIST_INF;
         for (int i = 0; i < n_cities; i++)
            if (marked[i] && best_dist[i] < bestd) begin
               bestd = best_dist[i];
               best = i;
            end
         if (best == 127) begin
            add_expected(single(ST_NO_CENTER));
            return;
         end
         n = 0;
         v = best;
         while (v < NCITY && n < NCITY) begin
            route[n++] = v;
            v = pred[v];
         end
         for (int k = 0; k < n; k++) begin
            r.status = ST_OK;
            r.center = best[5:0];
            r.total = bestd[16:0];
            r.city = route[n-1-k][5:0];
            r.last = (k == n - 1);
            add_expected(r);
         end
      end else add_expected(single(ST_REJECT));
   endtask

   // Result checking at the rising edge.
   always @(posedge clock) begin
      route_rsp_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_status, rsp_center_city, rsp_total_distance, rsp_path_city, rsp_last};
         n_rsp++;
         if (got.status == ST_OK && got.center != 0) n_routes++;
         if (route_q.size() == 0) begin
            $display("%0t: unexpected transaction, actual %p", $time, got);
            errors++;
         end else begin
            want = route_q.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
               errors++;
            end
         end
      end
   end

   // Receiver stalls and watchdog.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall);
   end

   always @(posedge clock) begin
      tx_accept = (req_valid && req_ready) || (rsp_valid && rsp_ready);
      if (reset || tx_accept) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   task automatic send_item(input logic [1:0] cmd, input logic mark, input logic [5:0] a,
                            input logic [5:0] b, input logic [15:0] w);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_cmd <= cmd;
      req_has_center <= mark;
      req_city_a <= a;
      req_city_b <= b;
      req_road_weight <= w;
      req_valid <= 1'b1;
      predict_centre(cmd, mark, a, b, w);
      n_items++;
      if (cmd == CMD_QUERY) n_query++;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(negedge clock);
      while (route_q.size() != 0) @(negedge clock);
   endtask

   task automatic random_item;
      int sel;
      logic [5:0] hi;
      sel = $urandom_range(99);
      hi = (n_cities == 0) ? 6'd0 : 6'(n_cities - 1);
      if (sel < 20)
         send_item(CMD_ADD_CITY, $urandom_range(3) == 0, 6'($urandom), 6'($urandom),
                   16'($urandom));
      else if (sel < 60)
         send_item(CMD_ADD_ROAD, 1'($urandom), 6'($urandom_range(hi)), 6'($urandom_range(hi)),
                   ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(50)));
      else if (sel < 90)
         send_item(CMD_QUERY, 1'($urandom), 6'($urandom_range(hi)), 6'($urandom),
                   16'($urandom));
      else
         send_item(2'($urandom), 1'($urandom), 6'($urandom), 6'($urandom), 16'($urandom));
   endtask

   stim_row_type plan[$];

   initial begin
      plan = '{
         '{CMD_QUERY,    1'b0, 6'd0,  6'd0,  16'd0,     1, ST_REJECT},
         '{CMD_ADD_ROAD, 1'b0, 6'd0,  6'd0,  16'd1,     1, ST_REJECT},
         '{2'd3,         1'b1, 6'd63, 6'd63, 16'hFFFF,  1, ST_REJECT},
         '{CMD_ADD_CITY, 1'b0, 6'd63, 6'd63, 16'hFFFF,  1, ST_OK},
         '{CMD_QUERY,    1'b0, 6'd0,  6'd0,  16'd0,     1, ST_NO_CENTER},
         '{CMD_ADD_CITY, 1'b1, 6'd0,  6'd0,  16'd0,     1, ST_OK},
         '{CMD_ADD_CITY, 1'b0, 6'd0,  6'd0,  16'd0,     1, ST_OK},
         '{CMD_ADD_CITY, 1'b1, 6'd0,  6'd0,  16'd0,     1, ST_OK},
         '{CMD_ADD_ROAD, 1'b1, 6'd0,  6'd63, 16'd5,     1, ST_REJECT},
         '{CMD_ADD_ROAD, 1'b0, 6'd0,  6'd0,  16'd0,     1, ST_OK},
         '{CMD_QUERY,    1'b0, 6'd0,  6'd0,  16'd0,     0, ST_OK},
         '{CMD_ADD_ROAD, 1'b0, 6'd0,  6'd1,  16'hFFFF,  1, ST_OK},
         '{CMD_ADD_ROAD, 1'b0, 6'd1,  6'd2,  16'hFFFF,  1, ST_OK},
         '{CMD_ADD_ROAD, 1'b0, 6'd3,  6'd2,  16'd0,     1, ST_OK},
         '{CMD_QUERY,    1'b0, 6'd2,  6'd0,  16'd0,     0, ST_OK},
         '{CMD_QUERY,    1'b0, 6'd0,  6'd0,  16'd0,     0, ST_OK},
         '{CMD_ADD_ROAD, 1'b0, 6'd2,  6'd1,  16'd7,     1, ST_OK},
         '{CMD_QUERY,    1'b1, 6'd1,  6'd0,  16'd0,     0, ST_OK},
         '{CMD_QUERY,    1'b0, 6'd3,  6'd0,  16'd0,     0, ST_OK},
         '{CMD_QUERY,    1'b0, 6'd4,  6'd0,  16'd0,     1, ST_REJECT}
      };
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         send_item(plan[i].cmd, plan[i].mark, plan[i].a, plan[i].b, plan[i].w);
         if (plan[i].typed) begin
            // The typed-in status is what the transaction is checked against.
            if (route_q[$].status !== plan[i].want_status) begin
               $display("%0t: mismatch, expected %0d, actual %0d", $time,
                        plan[i].want_status, route_q[$].status);
               errors++;
            end
            route_q[$].status = plan[i].want_status;
         end
      end
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle  = (phase == 1 || phase == 3) ? ((phase == 1) ? 71 : 7) : 0;
         recv_stall = (phase == 2 || phase == 3) ? ((phase == 2) ? 71 : 7) : 0;
         for (int k = 0; k < 20; k++) random_item();
         drain();
      end
      repeat (200) @(negedge clock);

      $display("Covered %0d transactions in, %0d results, %0d queries, %0d route cities.",
               n_items, n_rsp, n_query, n_routes);
      if (errors == 0 && route_q.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
hdl/nmsp_pkg.sv
hdl/nmsp_ram.sv
hdl/nmsp_dpath.sv
hdl/nmsp_ctrl.sv
hdl/nearest_marked_node_shortest_path_top.sv
test/nearest_marked_node_shortest_path_top_test.sv
